/* sv/cnl_pkg.sv */
package cnl_pkg;

  // command codes
  typedef enum logic [2:0] {
    CMD_APPEND = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_FIND   = 3'd2,
    CMD_DEDUP  = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // command word
  typedef struct packed {
    logic [2:0]  cmd;
    logic [23:0] key;
    logic [7:0]  depth;
    logic        check_duplicate;
    logic [5:0]  position;
  } req_t;

  // result word
  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  found_position;
    logic [6:0]  count;
    logic [23:0] entry_key;
    logic [7:0]  entry_depth;
  } rsp_t;

endpackage

/* sv/cnl_store.sv */
module cnl_store #(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [KEY_BITS-1:0]      wkey_i,
  input  logic [7:0]               wdep_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [KEY_BITS-1:0]      rkey_o,
  output logic [7:0]               rdep_o
);

  logic [KEY_BITS-1:0] key_mem [DEPTH];
  logic [7:0]          dep_mem [DEPTH];

  // single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[waddr_i] <= wkey_i;
      dep_mem[waddr_i] <= wdep_i;
    end
  end

  // single registered read port
  always_ff @(posedge clk_i) begin
    rkey_o <= key_mem[raddr_i];
    rdep_o <= dep_mem[raddr_i];
  end

endmodule

/* sv/compacting_neighbor_list.sv */
// channel   | signals                    | direction | handshake
// command   | start, busy, req_i         | in        | taken when start high and busy low
// result    | done_o, rsp_o              | out       | one word per command, one cycle wide
// config    | cfg_we_i, cfg_wdata_i      | in        | written on any edge with cfg_we_i high
//
// append without duplicate check, unknown codes and bad reads finish in the accept cycle;
// read answers from S_READ on the registered store data; find, remove and checked append
// scan one entry a cycle, remove then shifts one entry a cycle; duplicate removal scans
// the kept prefix per entry. the single read port of the key store sets these rates.
// reset clears the count and keep_depth; store contents stay undefined, no clearing pass.
// the receiver cannot stall: each result word is shown for exactly one cycle.
module compacting_neighbor_list #(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  cnl_pkg::req_t req_i,
  output logic          done_o,
  output cnl_pkg::rsp_t rsp_o,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 6) ? CW : 6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DLOAD,
    S_DSCAN,
    S_DWRITE,
    S_READ
  } state_e;

  state_e                state_q, state_d;
  cnl_pkg::cmd_e         cmd_q, cmd_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [7:0]            dep_q, dep_d;
  logic [AW-1:0]         ra_q, ra_d;
  logic [AW-1:0]         idx_q, idx_d;
  logic [CW-1:0]         wr_q, wr_d;
  logic [CW-1:0]         count_q, count_d;
  logic                  keep_q;
  logic                  done_q, done_d;
  cnl_pkg::rsp_t         rsp_q, rsp_d;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [KEY_BITS-1:0]   mem_wkey;
  logic [7:0]            mem_wdep;
  logic [KEY_BITS-1:0]   rkey;
  logic [7:0]            rdep;

  logic                  fin;
  cnl_pkg::status_e      st;
  logic [5:0]            fpos;
  logic [23:0]           ekey;
  logic [7:0]            edep;

  cnl_pkg::cmd_e         in_cmd;
  logic [KEY_BITS-1:0]   in_key;
  logic [7:0]            in_dep;
  logic                  ra_last;
  logic                  idx_last;
  logic                  list_full;

  // key and depth storage
  cnl_store #(
    .DEPTH    (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wkey_i  (mem_wkey),
    .wdep_i  (mem_wdep),
    .raddr_i (ra_d),
    .rkey_o  (rkey),
    .rdep_o  (rdep)
  );

  // incoming word, key masked to the stored width
  assign in_cmd    = cnl_pkg::cmd_e'(req_i.cmd);
  assign in_key    = KEY_BITS'(req_i.key);
  assign in_dep    = keep_q ? req_i.depth : 8'd0;
  assign ra_last   = (CW'(ra_q) + CW'(1)) == count_q;
  assign idx_last  = (CW'(idx_q) + CW'(1)) == count_q;
  assign list_full = count_q >= CW'(CAPACITY);

  // sequencer around the shared compare and the one read port
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    key_d     = key_q;
    dep_d     = dep_q;
    ra_d      = ra_q;
    idx_d     = idx_q;
    wr_d      = wr_q;
    count_d   = count_q;
    mem_we    = 1'b0;
    mem_waddr = ra_q;
    mem_wkey  = key_q;
    mem_wdep  = dep_q;
    fin       = 1'b0;
    st        = cnl_pkg::ST_OK;
    fpos      = '0;
    ekey      = '0;
    edep      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d = in_cmd;
          key_d = in_key;
          dep_d = in_dep;
          ra_d  = '0;
          unique case (in_cmd)
            cnl_pkg::CMD_APPEND: begin
              if (req_i.check_duplicate && (count_q != '0)) begin
                state_d = S_SCAN;
              end else begin
                fin = 1'b1;
                if (list_full) begin
                  st = cnl_pkg::ST_FULL;
                end else begin
                  mem_we    = 1'b1;
                  mem_waddr = AW'(count_q);
                  mem_wkey  = in_key;
                  mem_wdep  = in_dep;
                  count_d   = count_q + CW'(1);
                end
              end
            end
            cnl_pkg::CMD_REMOVE, cnl_pkg::CMD_FIND: begin
              if (count_q == '0) begin
                fin = 1'b1;
                st  = cnl_pkg::ST_MISSING;
              end else begin
                state_d = S_SCAN;
              end
            end
            cnl_pkg::CMD_DEDUP: begin
              idx_d = '0;
              wr_d  = '0;
              if (count_q == '0) begin
                fin = 1'b1;
              end else begin
                state_d = S_DLOAD;
              end
            end
            cnl_pkg::CMD_READ: begin
              if (PW'(req_i.position) < PW'(count_q)) begin
                ra_d    = AW'(req_i.position);
                state_d = S_READ;
              end else begin
                fin = 1'b1;
                st  = cnl_pkg::ST_MISSING;
              end
            end
            default: begin
              fin = 1'b1;
              st  = cnl_pkg::ST_MISSING;
            end
          endcase
        end
      end

      // first-match search, one entry a cycle
      S_SCAN: begin
        if (rkey == key_q) begin
          if (cmd_q == cnl_pkg::CMD_APPEND) begin
            fin     = 1'b1;
            st      = cnl_pkg::ST_PRESENT;
            state_d = S_IDLE;
          end else if (cmd_q == cnl_pkg::CMD_FIND) begin
            fin     = 1'b1;
            fpos    = 6'(ra_q);
            state_d = S_IDLE;
          end else if (ra_last) begin
            fin     = 1'b1;
            count_d = count_q - CW'(1);
            state_d = S_IDLE;
          end else begin
            ra_d    = ra_q + AW'(1);
            state_d = S_SHIFT;
          end
        end else if (ra_last) begin
          fin     = 1'b1;
          state_d = S_IDLE;
          if (cmd_q == cnl_pkg::CMD_APPEND) begin
            if (list_full) begin
              st = cnl_pkg::ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = AW'(count_q);
              count_d   = count_q + CW'(1);
            end
          end else begin
            st = cnl_pkg::ST_MISSING;
          end
        end else begin
          ra_d = ra_q + AW'(1);
        end
      end

      // move each later entry down by one
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = ra_q - AW'(1);
        mem_wkey  = rkey;
        mem_wdep  = rdep;
        if (ra_last) begin
          fin     = 1'b1;
          count_d = count_q - CW'(1);
          state_d = S_IDLE;
        end else begin
          ra_d = ra_q + AW'(1);
        end
      end

      // duplicate removal: hold entry i, then search the kept prefix
      S_DLOAD: begin
        key_d = rkey;
        dep_d = rdep;
        ra_d  = '0;
        if (wr_q == '0) begin
          state_d = S_DWRITE;
        end else begin
          state_d = S_DSCAN;
        end
      end

      S_DSCAN: begin
        if (rkey == key_q) begin
          if (idx_last) begin
            fin     = 1'b1;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + AW'(1);
            ra_d    = idx_q + AW'(1);
            state_d = S_DLOAD;
          end
        end else if ((CW'(ra_q) + CW'(1)) == wr_q) begin
          state_d = S_DWRITE;
        end else begin
          ra_d = ra_q + AW'(1);
        end
      end

      S_DWRITE: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(wr_q);
        wr_d      = wr_q + CW'(1);
        if (idx_last) begin
          fin     = 1'b1;
          count_d = wr_q + CW'(1);
          state_d = S_IDLE;
        end else begin
          idx_d   = idx_q + AW'(1);
          ra_d    = idx_q + AW'(1);
          state_d = S_DLOAD;
        end
      end

      // registered read data is ready
      S_READ: begin
        fin     = 1'b1;
        ekey    = 24'(rkey);
        edep    = keep_q ? rdep : 8'd0;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // at duplicate removal end the count is the kept number
    if (fin && (state_q == S_DSCAN)) begin
      count_d = wr_q;
    end

    done_d               = fin;
    rsp_d.status         = st;
    rsp_d.found_position = fpos;
    rsp_d.count          = 7'(count_d);
    rsp_d.entry_key      = ekey;
    rsp_d.entry_depth    = edep;
  end

  // state, working registers and result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= cnl_pkg::CMD_APPEND;
      key_q   <= '0;
      dep_q   <= '0;
      ra_q    <= '0;
      idx_q   <= '0;
      wr_q    <= '0;
      count_q <= '0;
      keep_q  <= 1'b0;
      done_q  <= 1'b0;
      rsp_q   <= '0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      key_q   <= key_d;
      dep_q   <= dep_d;
      ra_q    <= ra_d;
      idx_q   <= idx_d;
      wr_q    <= wr_d;
      count_q <= count_d;
      done_q  <= done_d;
      rsp_q   <= rsp_d;
      if (cfg_we_i) begin
        keep_q <= cfg_wdata_i;
      end
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // the count never exceeds the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // a result word only appears once the sequencer is back at rest
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE))
    else $error("result word while still working");

  // the count only moves together with a result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> done_q)
    else $error("count changed without a result");

  // the shift read pointer stays inside the list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (CW'(ra_q) < count_q))
    else $error("shift beyond the list end");

  // the kept prefix never overtakes the entry under test
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DLOAD) || (state_q == S_DSCAN) || (state_q == S_DWRITE))
      |-> (wr_q <= CW'(idx_q)))
    else $error("kept prefix overtook the entry under test");

endmodule

/* dv/tb_compacting_neighbor_list.sv */
module tb_compacting_neighbor_list;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY    = 64;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_WAIT  = 16;
  localparam int PHASE_WORDS = 140;

  // command codes the block does not define
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           start       = 1'b0;
  logic           busy;
  cnl_pkg::req_t  req         = '0;
  logic           done_o;
  cnl_pkg::rsp_t  rsp_o;
  logic           cfg_we_i    = 1'b0;
  logic           cfg_wdata_i = 1'b0;

  // shadow of the list as the block should hold it
  logic [23:0] key_mem [CAPACITY];
  logic [7:0]  depth_mem [CAPACITY];
  int          n_entries = 0;
  logic        keep_depth_q = 1'b0;

  cnl_pkg::rsp_t pending_results [$];
  int            errors = 0;
  int            idle_pct = 0;
  int            quiet_cycles = 0;
  logic [23:0]   key_pool [12];

  compacting_neighbor_list dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    for (int i = 0; i < CAPACITY; i++) begin
      key_mem[i]   = '0;
      depth_mem[i] = '0;
    end
  end

  // work out the result word of one command and update the shadow list
  task automatic apply_command(input cnl_pkg::req_t w, output cnl_pkg::rsp_t r);
    int  hit;
    int  kept;
    bit  seen;
    r = '0;
    r.status = cnl_pkg::ST_OK;
    hit = n_entries;
    for (int i = n_entries - 1; i >= 0; i--)
      if (key_mem[i] == w.key) hit = i;
    case (w.cmd)
      cnl_pkg::CMD_APPEND: begin
        if (w.check_duplicate && hit < n_entries) begin
          r.status = cnl_pkg::ST_PRESENT;
        end else if (n_entries >= CAPACITY) begin
          r.status = cnl_pkg::ST_FULL;
        end else begin
          key_mem[n_entries]   = w.key;
          depth_mem[n_entries] = keep_depth_q ? w.depth : 8'd0;
          n_entries++;
        end
      end
      cnl_pkg::CMD_REMOVE: begin
        if (hit >= n_entries) begin
          r.status = cnl_pkg::ST_MISSING;
        end else begin
          for (int j = hit; j + 1 < n_entries; j++) begin
            key_mem[j]   = key_mem[j + 1];
            depth_mem[j] = depth_mem[j + 1];
          end
          n_entries--;
        end
      end
      cnl_pkg::CMD_FIND: begin
        if (hit >= n_entries) r.status = cnl_pkg::ST_MISSING;
        else r.found_position = 6'(hit);
      end
      cnl_pkg::CMD_DEDUP: begin
        kept = 0;
        for (int i = 0; i < n_entries; i++) begin
          seen = 1'b0;
          for (int j = 0; j < kept; j++)
            if (key_mem[j] == key_mem[i]) seen = 1'b1;
          if (!seen) begin
            key_mem[kept]   = key_mem[i];
            depth_mem[kept] = depth_mem[i];
            kept++;
          end
        end
        n_entries = kept;
      end
      cnl_pkg::CMD_READ: begin
        if (int'(w.position) >= n_entries) begin
          r.status = cnl_pkg::ST_MISSING;
        end else begin
          r.entry_key   = key_mem[w.position];
          r.entry_depth = keep_depth_q ? depth_mem[w.position] : 8'd0;
        end
      end
      default: r.status = cnl_pkg::ST_MISSING;
    endcase
    r.count = 7'(n_entries);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // take commands and register writes, compare result words, watch for a hang
  always @(posedge clk_i) begin
    cnl_pkg::rsp_t want;
    if (rst_ni) begin
      if (cfg_we_i) keep_depth_q <= cfg_wdata_i;
      if (start && !busy) begin
        apply_command(req, want);
        pending_results.push_back(want);
      end
      if (done_o) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result word with none expected, got %h", $time, rsp_o);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", 32'(want.status), 32'(rsp_o.status));
          check_field("found_position", 32'(want.found_position),
                      32'(rsp_o.found_position));
          check_field("count", 32'(want.count), 32'(rsp_o.count));
          check_field("entry_key", 32'(want.entry_key), 32'(rsp_o.entry_key));
          check_field("entry_depth", 32'(want.entry_depth), 32'(rsp_o.entry_depth));
        end
      end
      if ((start && !busy) || done_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // present one command word, with an optional gap first, until taken
  task automatic send_word(input logic [2:0] op, input logic [23:0] k,
                           input logic [7:0] d, input logic chk, input logic [5:0] p);
    cnl_pkg::req_t w;
    w.cmd             = op;
    w.key             = k;
    w.depth           = d;
    w.check_duplicate = chk;
    w.position        = p;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    req   <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // stop sending and wait for every outstanding result
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_keep_depth(input logic v);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // empty list, key extremes, duplicate refusal, bad positions, spare codes
  task automatic test_basic_commands();
    send_word(cnl_pkg::CMD_READ, 24'h0, 8'h0, 1'b0, 6'd0);
    send_word(cnl_pkg::CMD_READ, 24'h0, 8'h0, 1'b0, 6'd63);
    send_word(cnl_pkg::CMD_REMOVE, 24'h000123, 8'h0, 1'b0, 6'd0);
    send_word(cnl_pkg::CMD_FIND, 24'hFFFFFF, 8'h0, 1'b0, 6'd0);
    send_word(cnl_pkg::CMD_APPEND, 24'h000000, 8'hFF, 1'b0, 6'd0);
    send_word(cnl_pkg::CMD_APPEND, 24'hFFFFFF, 8'hAA, 1'b1, 6'd0);
    send_word(cnl_pkg::CMD_APPEND, 24'hFFFFFF, 8'h55, 1'b1, 6'd0);
    send_word(cnl_pkg::CMD_APPEND, 24'h000000, 8'h01, 1'b0, 6'd0);
    send_word(cnl_pkg::CMD_FIND, 24'hFFFFFF, 8'h0, 1'b0, 6'd0);
    send_word(cnl_pkg::CMD_READ, 24'h0, 8'h0, 1'b0, 6'd1);
    send_word(cnl_pkg::CMD_READ, 24'h0, 8'h0, 1'b0, 6'd3);
    send_word(cnl_pkg::CMD_DEDUP, 24'h0, 8'h0, 1'b0, 6'd0);
    send_word(cnl_pkg::CMD_READ, 24'h0, 8'h0, 1'b0, 6'd1);
    send_word(cnl_pkg::CMD_REMOVE, 24'h000000, 8'h0, 1'b0, 6'd0);
    send_word(cnl_pkg::CMD_FIND, 24'hFFFFFF, 8'h0, 1'b0, 6'd0);
    for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
      send_word(3'(c), 24'hFFFFFF, 8'hFF, 1'b1, 6'd63);
  endtask

  // depths stored, moved by duplicate removal and by the shift after remove
  task automatic test_depth_moves();
    write_keep_depth(1'b1);
    send_word(cnl_pkg::CMD_APPEND, 24'h00A001, 8'h11, 1'b0, 6'd0);
    send_word(cnl_pkg::CMD_APPEND, 24'h00A002, 8'h22, 1'b0, 6'd0);
    send_word(cnl_pkg::CMD_APPEND, 24'h00A001, 8'h33, 1'b0, 6'd0);
    send_word(cnl_pkg::CMD_APPEND, 24'h00A003, 8'hFF, 1'b0, 6'd0);
    send_word(cnl_pkg::CMD_DEDUP, 24'h0, 8'h0, 1'b0, 6'd0);
    send_word(cnl_pkg::CMD_READ, 24'h0, 8'h0, 1'b0, 6'd1);
    send_word(cnl_pkg::CMD_READ, 24'h0, 8'h0, 1'b0, 6'd2);
    send_word(cnl_pkg::CMD_REMOVE, 24'h00A002, 8'h0, 1'b0, 6'd0);
    send_word(cnl_pkg::CMD_READ, 24'h0, 8'h0, 1'b0, 6'd1);
  endtask

  // fill to capacity with some repeated keys, then full and refusal cases
  task automatic test_full_list();
    for (int i = 0; i < CAPACITY; i++)
      send_word(cnl_pkg::CMD_APPEND, 24'h100000 + 24'(i % 48), 8'(i), 1'b0, 6'd0);
    send_word(cnl_pkg::CMD_APPEND, 24'h7FFFFF, 8'h80, 1'b0, 6'd0);
    send_word(cnl_pkg::CMD_APPEND, 24'h100000, 8'h80, 1'b1, 6'd0);
    send_word(cnl_pkg::CMD_APPEND, 24'h7FFFFF, 8'h80, 1'b1, 6'd0);
    send_word(cnl_pkg::CMD_READ, 24'h0, 8'h0, 1'b0, 6'd63);
    send_word(cnl_pkg::CMD_FIND, 24'h100000, 8'h0, 1'b0, 6'd0);
    send_word(cnl_pkg::CMD_REMOVE, 24'h100000, 8'h0, 1'b0, 6'd0);
    send_word(cnl_pkg::CMD_DEDUP, 24'h0, 8'h0, 1'b0, 6'd0);
    send_word(cnl_pkg::CMD_READ, 24'h0, 8'h0, 1'b0, 6'd47);
  endtask

  // mostly keys already in the list or from a small pool, some fully random
  task automatic send_random_word();
    int          n;
    int          roll;
    int          app;
    logic [2:0]  op;
    logic [23:0] k;
    logic [5:0]  p;
    n    = n_entries;
    app  = (n < 40) ? 45 : 20;
    roll = $urandom_range(0, 99);
    if (roll < app) op = cnl_pkg::CMD_APPEND;
    else if (roll < app + 20) op = cnl_pkg::CMD_REMOVE;
    else if (roll < app + 35) op = cnl_pkg::CMD_FIND;
    else if (roll < app + 40) op = cnl_pkg::CMD_DEDUP;
    else if (roll < app + 43) op = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
    else op = cnl_pkg::CMD_READ;
    roll = $urandom_range(0, 99);
    if (n > 0 && roll < 50) k = key_mem[$urandom_range(0, n - 1)];
    else if (roll < 80) k = key_pool[$urandom_range(0, 11)];
    else k = 24'($urandom);
    if (n > 0 && $urandom_range(0, 9) < 7) p = 6'($urandom_range(0, n - 1));
    else p = 6'($urandom_range(0, 63));
    send_word(op, k, 8'($urandom), 1'($urandom), p);
  endtask

  task automatic test_random_traffic();
    int gaps [4];
    gaps = '{0, 61, 0, 16};
    for (int ph = 0; ph < 4; ph++) begin
      write_keep_depth(ph[0]);
      for (int i = 0; i < 12; i++) key_pool[i] = 24'($urandom);
      key_pool[0] = 24'h000000;
      key_pool[1] = 24'hFFFFFF;
      idle_pct = gaps[ph];
      for (int i = 0; i < PHASE_WORDS; i++) begin
        // hold off once until the list has answered everything
        if (ph == 1 && i == PHASE_WORDS / 2) settle();
        send_random_word();
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_commands();
    test_depth_moves();
    test_full_list();
    test_random_traffic();
    write_keep_depth(1'b0);
    send_word(cnl_pkg::CMD_READ, 24'h0, 8'h0, 1'b0, 6'd0);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* compacting_neighbor_list.f */
sv/cnl_pkg.sv
sv/cnl_store.sv
sv/compacting_neighbor_list.sv
dv/tb_compacting_neighbor_list.sv
